/* design/ctp_pkg.sv */
// shared types and constants for the concentric circle test pattern pixel core
package ctp_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned PAD_BITS   = 8;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned PIXEL_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = 4;
  localparam int unsigned APB_DATA_BITS = 32;

  localparam logic [COORD_BITS-1:0] WIDTH_RESET   = COORD_BITS'(500);
  localparam logic [COORD_BITS-1:0] HEIGHT_RESET  = COORD_BITS'(550);
  localparam logic [PAD_BITS-1:0]   PADDING_RESET = PAD_BITS'(20);

  // shading constants
  localparam logic [31:0] SHADE_MULT       = 32'h0008_0401;
  localparam int unsigned COLOUR_BITS      = 24;
  localparam logic [7:0]  ALPHA_OPAQUE     = 8'hff;
  localparam logic [7:0]  ALPHA_CLEAR      = 8'h00;
  localparam int unsigned RADIUS_MARGIN    = 8;
  localparam int unsigned RING_WIDTH       = 32;
  localparam int unsigned R2_SHIFT         = 5;
  localparam int unsigned INNER_TIME_SHIFT = 6;
  localparam int unsigned RING_TIME_SHIFT  = 5;
  localparam int unsigned OUTER_TIME_SHIFT = 4;
  localparam int unsigned DIAG_HALF        = 6;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_BORDER_PADDING = 2'd2
  } ctp_reg_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] frame_width;
    logic [COORD_BITS-1:0] frame_height;
    logic [PAD_BITS-1:0]   border_padding;
  } ctp_cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [TIME_BITS-1:0]  anim_time;
  } ctp_pix_in_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_value;
    logic                  pixel_written;
  } ctp_pix_out_t;

endpackage

/* design/ctp_regs.sv */
// apb configuration registers for frame size and border padding
module ctp_regs
  import ctp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output ctp_cfg_t                 cfg_o
);

  ctp_cfg_t cfg_q, cfg_d;
  logic     wr_en;
  ctp_reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = ctp_reg_e'(paddr[APB_ADDR_BITS-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:    cfg_d.frame_width    = pwdata[COORD_BITS-1:0];
        REG_FRAME_HEIGHT:   cfg_d.frame_height   = pwdata[COORD_BITS-1:0];
        REG_BORDER_PADDING: cfg_d.border_padding = pwdata[PAD_BITS-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:    prdata = APB_DATA_BITS'(cfg_q.frame_width);
      REG_FRAME_HEIGHT:   prdata = APB_DATA_BITS'(cfg_q.frame_height);
      REG_BORDER_PADDING: prdata = APB_DATA_BITS'(cfg_q.border_padding);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= WIDTH_RESET;
      cfg_q.frame_height   <= HEIGHT_RESET;
      cfg_q.border_padding <= PADDING_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/circle_test_pattern_pixel_core.sv */
// concentric circle test pattern: one xrgb pixel per position and time
//
//   port group   direction  handshake               payload
//   in_*         input      in_valid_i / in_stall_o    ctp_pix_in_t
//   out_*        output     out_valid_o / out_stall_i  ctp_pix_out_t
//   apb          input      psel, penable / pready     3 registers
//
// one pixel per clock cycle sustained while no held result is refused; the result
// passes through the five pipeline stages (bounds, offsets, squares, band select,
// colour multiply), the first of which loads on the transfer edge itself and the
// last of which is the output register.
// reset clears all stage valid bits and loads width 500, height 550, padding 20.
// a stall on a held output result freezes the whole pipeline and stalls the input
// in the same cycle, so no pixel is dropped or repeated.
module circle_test_pattern_pixel_core
  import ctp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  ctp_pix_in_t              in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output ctp_pix_out_t             out_data_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int unsigned SW = COORD_BITS + 2;  // signed frame arithmetic
  localparam int unsigned DW = COORD_BITS + 3;  // signed offsets from the centre
  localparam int unsigned SQ = 2 * DW;          // full square width
  localparam int unsigned D2 = 2 * COORD_BITS + 1;  // offset square kept
  localparam int unsigned R2 = D2 + 1;          // squared distance
  localparam int unsigned RQ = 2 * COORD_BITS;  // squared radius kept
  localparam logic signed [SW-1:0] DiagLim   = SW'(DIAG_HALF);
  localparam logic signed [SW-1:0] MarginVal = SW'(RADIUS_MARGIN);
  localparam logic signed [SW-1:0] RingVal   = SW'(RING_WIDTH);

  ctp_cfg_t cfg;

  ctp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic advance;

  // stage valid bits
  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q, out_valid_q;

  // stage a: bounds, centre, diagonals
  logic [COORD_BITS-1:0] a_x_q, a_y_q;
  logic [TIME_BITS-1:0]  a_t_q;
  logic signed [SW-1:0]  a_halfw_q, a_halfh_q;
  logic                  a_inside_q, a_diag_q;
  logic signed [SW-1:0]  a_halfw_d, a_halfh_d;
  logic                  a_inside_d, a_diag_d;
  logic signed [SW-1:0]  xs, ys, ws, hs, ps, dw, dh, wlim, hlim, dxy, sxy;

  always_comb begin
    xs   = $signed(SW'(in_data_i.pixel_x));
    ys   = $signed(SW'(in_data_i.pixel_y));
    ws   = $signed(SW'(cfg.frame_width));
    hs   = $signed(SW'(cfg.frame_height));
    ps   = $signed(SW'(cfg.border_padding));
    wlim = ws - ps;
    hlim = hs - ps;
    dw   = ws - (ps <<< 1);
    dh   = hs - (ps <<< 1);
    // halving truncates toward zero
    a_halfw_d  = ps + ((dw + $signed(SW'(dw[SW-1]))) >>> 1);
    a_halfh_d  = ps + ((dh + $signed(SW'(dh[SW-1]))) >>> 1);
    a_inside_d = (xs >= ps) && (xs < wlim) && (ys >= ps) && (ys < hlim);
    dxy        = xs - ys;
    sxy        = xs + ys - hs;
    a_diag_d   = ((dxy >= -DiagLim) && (dxy <= DiagLim)) ||
                 ((sxy >= -DiagLim) && (sxy <= DiagLim));
  end

  // stage b: offsets and radius bases
  logic [COORD_BITS-1:0] b_x_q, b_y_q;
  logic [TIME_BITS-1:0]  b_t_q;
  logic signed [DW-1:0]  b_dx_q, b_dy_q;
  logic signed [SW-1:0]  b_ob_q, b_ib_q;
  logic                  b_inside_q, b_diag_q;
  logic signed [DW-1:0]  b_dx_d, b_dy_d;
  logic signed [SW-1:0]  b_ob_d, b_ib_d, rmin;

  always_comb begin
    b_dx_d = $signed(DW'(a_x_q)) - $signed({a_halfw_q[SW-1], a_halfw_q});
    b_dy_d = $signed(DW'(a_y_q)) - $signed({a_halfh_q[SW-1], a_halfh_q});
    rmin   = (a_halfw_q < a_halfh_q) ? a_halfw_q : a_halfh_q;
    b_ob_d = rmin - MarginVal;
    b_ib_d = b_ob_d - RingVal;
  end

  // stage c: squares
  logic [COORD_BITS-1:0] c_x_q, c_y_q;
  logic [TIME_BITS-1:0]  c_t_q;
  logic [D2-1:0]         c_dx2_q, c_dy2_q;
  logic [RQ-1:0]         c_orad2_q, c_irad2_q;
  logic                  c_inside_q, c_diag_q;
  logic signed [SQ-1:0]  dx2_full, dy2_full;
  logic signed [2*SW-1:0] ob2_full, ib2_full;

  always_comb begin
    dx2_full = b_dx_q * b_dx_q;
    dy2_full = b_dy_q * b_dy_q;
    ob2_full = b_ob_q * b_ob_q;
    ib2_full = b_ib_q * b_ib_q;
  end

  // stage d: band select and time scroll
  logic [COLOUR_BITS-1:0] d_shade_q;
  logic                   d_inside_q, d_diag_q;
  logic [COLOUR_BITS-1:0] d_shade_d;
  logic [R2-1:0]          r2;
  logic [TIME_BITS-1:0]   shade_full;

  always_comb begin
    r2 = R2'(c_dx2_q) + R2'(c_dy2_q);
    if (r2 < R2'(c_irad2_q)) begin
      shade_full = TIME_BITS'(r2 >> R2_SHIFT) + (c_t_q >> INNER_TIME_SHIFT);
    end else if (r2 < R2'(c_orad2_q)) begin
      shade_full = TIME_BITS'(c_y_q) + (c_t_q >> RING_TIME_SHIFT);
    end else begin
      shade_full = TIME_BITS'(c_x_q) + (c_t_q >> OUTER_TIME_SHIFT);
    end
    d_shade_d = shade_full[COLOUR_BITS-1:0];
  end

  // stage e: colour multiply into the output register
  ctp_pix_out_t out_q, out_d;
  logic [COLOUR_BITS-1:0] colour;

  always_comb begin
    colour = COLOUR_BITS'(d_shade_q * SHADE_MULT[COLOUR_BITS-1:0]);
    out_d.pixel_written = d_inside_q;
    if (d_inside_q) begin
      out_d.pixel_value = {(d_diag_q ? ALPHA_CLEAR : ALPHA_OPAQUE), colour};
    end else begin
      out_d.pixel_value = '0;
    end
  end

  // the whole pipeline moves together unless the held result is refused
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      a_valid_q   <= in_valid_i;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      d_valid_q   <= c_valid_q;
      out_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_x_q      <= in_data_i.pixel_x;
      a_y_q      <= in_data_i.pixel_y;
      a_t_q      <= in_data_i.anim_time;
      a_halfw_q  <= a_halfw_d;
      a_halfh_q  <= a_halfh_d;
      a_inside_q <= a_inside_d;
      a_diag_q   <= a_diag_d;

      b_x_q      <= a_x_q;
      b_y_q      <= a_y_q;
      b_t_q      <= a_t_q;
      b_dx_q     <= b_dx_d;
      b_dy_q     <= b_dy_d;
      b_ob_q     <= b_ob_d;
      b_ib_q     <= b_ib_d;
      b_inside_q <= a_inside_q;
      b_diag_q   <= a_diag_q;

      c_x_q      <= b_x_q;
      c_y_q      <= b_y_q;
      c_t_q      <= b_t_q;
      c_dx2_q    <= dx2_full[D2-1:0];
      c_dy2_q    <= dy2_full[D2-1:0];
      c_orad2_q  <= ob2_full[RQ-1:0];
      c_irad2_q  <= ib2_full[RQ-1:0];
      c_inside_q <= b_inside_q;
      c_diag_q   <= b_diag_q;

      d_shade_q  <= d_shade_d;
      d_inside_q <= c_inside_q;
      d_diag_q   <= c_diag_q;

      out_q      <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/ctp_checker.sv */
// port-level checks for the test pattern pixel core, bound to the top level
module ctp_checker
  import ctp_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_stall_o,
  input logic         out_valid_o,
  input logic         out_stall_i,
  input ctp_pix_out_t out_data_o
);

  // a refused result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // input back-pressure only comes from a refused result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_blank_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.pixel_written |-> out_data_o.pixel_value == '0)
    else $error("pixel outside padded area is not blank");

  a_alpha_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pixel_written |->
      out_data_o.pixel_value[31:24] == ALPHA_OPAQUE ||
      out_data_o.pixel_value[31:24] == ALPHA_CLEAR)
    else $error("alpha byte neither opaque nor clear");

endmodule

bind circle_test_pattern_pixel_core ctp_checker u_ctp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* test/tb_top.sv */
// self-checking testbench for the concentric circle test pattern pixel core
module tb_top;
  import ctp_pkg::*;

  localparam int unsigned NUM_PLANS      = 9;
  localparam int unsigned PLAN_PIXELS    = 160;
  localparam int unsigned GAP_PERCENT    = 35;
  localparam int unsigned HOLD_CYCLES    = 160;
  localparam int unsigned HOLD_AFTER     = 400;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  // frame settings walked through after the directed pixels
  localparam int unsigned PLAN_WIDTH[NUM_PLANS]  = '{64, 500, 4095, 1, 100, 10, 300, 4095, 1000};
  localparam int unsigned PLAN_HEIGHT[NUM_PLANS] = '{48, 550, 4095, 1, 200, 10, 120, 20, 1000};
  localparam int unsigned PLAN_PAD[NUM_PLANS]    = '{0, 20, 255, 0, 255, 0, 7, 3, 128};

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall_o;
  ctp_pix_in_t              in_data = '0;
  logic                     out_valid_o;
  logic                     out_stall = 1'b0;
  ctp_pix_out_t             out_data_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  ctp_cfg_t     pattern_cfg = '{frame_width: WIDTH_RESET, frame_height: HEIGHT_RESET,
                                border_padding: PADDING_RESET};
  ctp_pix_in_t  pending_pixels[$];
  ctp_pix_out_t expected_pixels[$];

  bit          gapless = 1'b0;
  bit          in_taken = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned pixels_seen = 0;
  int unsigned painted_seen = 0;
  int unsigned error_count = 0;

  circle_test_pattern_pixel_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // expected pixel for the current frame settings
  function automatic ctp_pix_out_t shade_pixel(ctp_pix_in_t px);
    longint w, h, pad, x, y, halfw, halfh, rbase, outer_r2, inner_r2, r2, d1, d2;
    logic [31:0] t, shade;
    ctp_pix_out_t res;
    w   = pattern_cfg.frame_width;
    h   = pattern_cfg.frame_height;
    pad = pattern_cfg.border_padding;
    x   = px.pixel_x;
    y   = px.pixel_y;
    t   = px.anim_time;
    res = '0;
    if (!(x >= pad && x < w - pad && y >= pad && y < h - pad)) return res;
    // signed division truncates toward zero, as wanted when the padding swamps the frame
    halfh    = pad + (h - pad * 2) / 2;
    halfw    = pad + (w - pad * 2) / 2;
    rbase    = ((halfw < halfh) ? halfw : halfh) - RADIUS_MARGIN;
    outer_r2 = rbase * rbase;
    inner_r2 = (rbase - RING_WIDTH) * (rbase - RING_WIDTH);
    r2       = (x - halfw) * (x - halfw) + (y - halfh) * (y - halfh);
    if (r2 < inner_r2) shade = 32'(r2 >>> R2_SHIFT) + (t >> INNER_TIME_SHIFT);
    else if (r2 < outer_r2) shade = 32'(y) + (t >> RING_TIME_SHIFT);
    else shade = 32'(x) + (t >> OUTER_TIME_SHIFT);
    shade = shade * SHADE_MULT;
    d1 = x - y;
    d2 = x + y - h;
    if (d1 < 0) d1 = -d1;
    if (d2 < 0) d2 = -d2;
    res.pixel_value = {(d1 > DIAG_HALF && d2 > DIAG_HALF) ? ALPHA_OPAQUE : ALPHA_CLEAR,
                       shade[COLOUR_BITS-1:0]};
    res.pixel_written = 1'b1;
    return res;
  endfunction

  // mostly positions within the frame, some on the diagonals, a few anywhere
  function automatic ctp_pix_in_t random_pixel();
    ctp_pix_in_t px;
    int unsigned pick, w, h;
    int d;
    w = pattern_cfg.frame_width;
    h = pattern_cfg.frame_height;
    pick = $urandom_range(99);
    d = int'($urandom_range(16)) - 8;
    if ($urandom_range(9) == 0) px.anim_time = ($urandom_range(1) == 0) ? '0 : '1;
    else px.anim_time = $urandom();
    if (pick < 12) begin
      px.pixel_x = COORD_BITS'($urandom());
      px.pixel_y = COORD_BITS'($urandom());
    end else if (pick < 30) begin
      px.pixel_x = COORD_BITS'($urandom_range(w - 1));
      if (pick < 21) px.pixel_y = COORD_BITS'(int'(px.pixel_x) + d);
      else px.pixel_y = COORD_BITS'(int'(h) - int'(px.pixel_x) + d);
    end else begin
      px.pixel_x = COORD_BITS'($urandom_range(w - 1));
      px.pixel_y = COORD_BITS'($urandom_range(h - 1));
    end
    return px;
  endfunction

  task automatic queue_pixel(int unsigned x, int unsigned y, logic [31:0] t);
    pending_pixels.push_back('{pixel_x: COORD_BITS'(x), pixel_y: COORD_BITS'(y), anim_time: t});
  endtask

  // write then read back one register
  task automatic set_register(ctp_reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'(4 * int'(idx));
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_FRAME_WIDTH:    pattern_cfg.frame_width    = value[COORD_BITS-1:0];
      REG_FRAME_HEIGHT:   pattern_cfg.frame_height   = value[COORD_BITS-1:0];
      REG_BORDER_PADDING: pattern_cfg.border_padding = value[PAD_BITS-1:0];
      default:            ;
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value)
      report_mismatch($sformatf("%s reads back %h, wrote %h", idx.name(), prdata, value));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain_pixels();
    while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // sender: a payload stays put until its transfer, gaps only between transfers
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (pending_pixels.size() != 0 && (gapless || $urandom_range(99) >= GAP_PERCENT)) begin
        in_data  <= pending_pixels.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off while the sender still has plenty queued
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && pixels_seen >= HOLD_AFTER && pending_pixels.size() >= 50) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !gapless && $urandom_range(99) < GAP_PERCENT;
      end
    end
  end

  // output checks first, then the input transfer of the same edge is predicted
  always @(posedge clk_i) begin
    ctp_pix_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel %h", out_data_o));
        end else begin
          want = expected_pixels.pop_front();
          if (out_data_o.pixel_value !== want.pixel_value)
            report_mismatch($sformatf("pixel_value %h, expected %h",
                                      out_data_o.pixel_value, want.pixel_value));
          if (out_data_o.pixel_written !== want.pixel_written)
            report_mismatch($sformatf("pixel_written %b, expected %b",
                                      out_data_o.pixel_written, want.pixel_written));
        end
        pixels_seen++;
        if (out_data_o.pixel_written === 1'b1) painted_seen++;
      end
      in_taken = in_valid && !in_stall_o;
      if (in_taken) expected_pixels.push_back(shade_pixel(in_data));
      if (in_taken || (out_valid_o && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned p, n;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed pixels on the reset frame: 500 x 550, padding 20
    queue_pixel(0, 0, 32'h0);
    queue_pixel(19, 20, 32'h1234_5678);
    queue_pixel(20, 20, 32'h0);
    queue_pixel(479, 529, 32'hffff_ffff);
    queue_pixel(480, 100, 32'h0);
    queue_pixel(100, 530, 32'h0);
    queue_pixel(4095, 4095, 32'hffff_ffff);
    queue_pixel(20, 4095, 32'h0);
    queue_pixel(250, 275, 32'h0);
    queue_pixel(250, 275, 32'hffff_ffff);
    queue_pixel(250, 495, 32'h1234_5678);
    queue_pixel(30, 40, 32'hffff_ffff);
    queue_pixel(100, 106, 32'h0);
    queue_pixel(100, 107, 32'h0);
    queue_pixel(300, 256, 32'h5);
    queue_pixel(300, 257, 32'h5);
    queue_pixel(300, 243, 32'h5);
    queue_pixel(300, 244, 32'h5);
    // edges of the ring and of the inner circle
    queue_pixel(250, 33, 32'h8000_0000);
    queue_pixel(250, 34, 32'h8000_0000);
    queue_pixel(250, 65, 32'h7fff_ffff);
    queue_pixel(250, 66, 32'h7fff_ffff);
    drain_pixels();

    for (p = 0; p < NUM_PLANS; p++) begin
      set_register(REG_FRAME_WIDTH, PLAN_WIDTH[p]);
      set_register(REG_FRAME_HEIGHT, PLAN_HEIGHT[p]);
      set_register(REG_BORDER_PADDING, PLAN_PAD[p]);
      gapless = (p == 0);
      for (n = 0; n < PLAN_PIXELS; n++) pending_pixels.push_back(random_pixel());
      drain_pixels();
      gapless = 1'b0;
    end

    $display("checked %0d pixels, %0d inside the padded area, over %0d frame settings",
             pixels_seen, painted_seen, NUM_PLANS + 1);
    $display("included a gap-free stretch and a %0d-cycle output hold-off", HOLD_CYCLES);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
